// ===== hdl/rgb_to_hsv_pixel_converter_assert.svh =====
// Assertion macros for the RGB to HSV converter.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef RGB_TO_HSV_PIXEL_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_CONVERTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define R2H_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("r2h assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define R2H_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("r2h assertion failed");

`endif

// ===== hdl/r2h_pkg.sv =====
// Shared widths, types and codes for the RGB to HSV converter.
// No dependencies; used by r2h_div_stage and the top level.
package r2h_pkg;

  localparam int unsigned PIX_W  = 8;               // channel width
  localparam int unsigned Q_W    = 8;               // quotient width, one stage per bit
  localparam int unsigned HDEN_W = 11;              // 6*d, at most 1530
  localparam int unsigned HNUM_W = HDEN_W + Q_W;    // 255*n, below 2^19
  localparam int unsigned SDEN_W = PIX_W;           // maximum channel
  localparam int unsigned SNUM_W = PIX_W + Q_W;     // 255*d

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } r2h_sel_t;

  // Sideband that travels beside the division data.
  typedef struct packed {
    logic             valid;
    logic             gray;
    logic             frame_end;
    logic [PIX_W-1:0] val;
  } r2h_ctl_t;

endpackage

// ===== hdl/r2h_div_stage.sv =====
// One restoring division step for both hue and saturation quotients.
// Depends on r2h_pkg for widths and the sideband struct.
module r2h_div_stage
  import r2h_pkg::*;
#(
  parameter int unsigned BIT = Q_W - 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  r2h_ctl_t          ctl_i,
  input  logic [HNUM_W-1:0] hrem_i,
  input  logic [HDEN_W-1:0] hden_i,
  input  logic [Q_W-1:0]    hq_i,
  input  logic [SNUM_W-1:0] srem_i,
  input  logic [SDEN_W-1:0] sden_i,
  input  logic [Q_W-1:0]    sq_i,
  output r2h_ctl_t          ctl_o,
  output logic [HNUM_W-1:0] hrem_o,
  output logic [HDEN_W-1:0] hden_o,
  output logic [Q_W-1:0]    hq_o,
  output logic [SNUM_W-1:0] srem_o,
  output logic [SDEN_W-1:0] sden_o,
  output logic [Q_W-1:0]    sq_o
);

  logic [HNUM_W-1:0] hsh;
  logic [SNUM_W-1:0] ssh;
  logic              hge;
  logic              sge;

  logic              valid_r;
  r2h_ctl_t          ctl_r;
  logic [HNUM_W-1:0] hrem_r, hrem_nxt;
  logic [HDEN_W-1:0] hden_r;
  logic [Q_W-1:0]    hq_r, hq_nxt;
  logic [SNUM_W-1:0] srem_r, srem_nxt;
  logic [SDEN_W-1:0] sden_r;
  logic [Q_W-1:0]    sq_r, sq_nxt;

  // The partial remainder is always below twice the shifted divisor, so one
  // compare and subtract settles this quotient bit.
  assign hsh = HNUM_W'(hden_i) << BIT;
  assign ssh = SNUM_W'(sden_i) << BIT;
  assign hge = (hrem_i >= hsh);
  assign sge = (srem_i >= ssh);

  always_comb begin
    hrem_nxt = hge ? (hrem_i - hsh) : hrem_i;
    srem_nxt = sge ? (srem_i - ssh) : srem_i;
    hq_nxt      = hq_i;
    hq_nxt[BIT] = hge;
    sq_nxt      = sq_i;
    sq_nxt[BIT] = sge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r  <= ctl_i;
    hrem_r <= hrem_nxt;
    hden_r <= hden_i;
    hq_r   <= hq_nxt;
    srem_r <= srem_nxt;
    sden_r <= sden_i;
    sq_r   <= sq_nxt;
  end

  always_comb begin
    ctl_o       = ctl_r;
    ctl_o.valid = valid_r;
  end

  assign hrem_o = hrem_r;
  assign hden_o = hden_r;
  assign hq_o   = hq_r;
  assign srem_o = srem_r;
  assign sden_o = sden_r;
  assign sq_o   = sq_r;

endmodule

// ===== hdl/rgb_to_hsv_pixel_converter.sv =====
// RGB to HSV converter: 8-bit RGB channels in, saturation, hue and value bytes out.
// Pipeline from an accepted request to out_valid: three setup stages
// (max/min, hue numerator, scaling) and eight division stages, one quotient bit each.
// Throughput is one pixel per cycle; busy stays low since the receiver cannot stall.
// Reset (synchronous, active low) clears every valid bit; data registers are not reset.
// Depends on r2h_pkg, r2h_div_stage and rgb_to_hsv_pixel_converter_assert.svh.
module rgb_to_hsv_pixel_converter
  import r2h_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [PIX_W-1:0] in_red,
  input  logic [PIX_W-1:0] in_green,
  input  logic [PIX_W-1:0] in_blue,
  input  logic             in_frame_end,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_sat_out,
  output logic [PIX_W-1:0] out_hue_out,
  output logic [PIX_W-1:0] out_val_out,
  output logic             out_frame_end_out
);

  localparam int unsigned LATENCY = 3 + Q_W;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage A: maximum, minimum and the signed channel difference.
  logic             rge, rgeb, gge;
  logic [PIX_W-1:0] mx, mn;
  r2h_sel_t         sel;
  logic signed [PIX_W:0] diff;

  always_comb begin
    rge  = (in_red >= in_green);
    rgeb = (in_red >= in_blue);
    gge  = (in_green >= in_blue);
    if (rge && rgeb) begin
      sel  = MAX_RED;
      mx   = in_red;
      diff = signed'({1'b0, in_green}) - signed'({1'b0, in_blue});
    end else if (gge) begin
      sel  = MAX_GREEN;
      mx   = in_green;
      diff = signed'({1'b0, in_blue}) - signed'({1'b0, in_red});
    end else begin
      sel  = MAX_BLUE;
      mx   = in_blue;
      diff = signed'({1'b0, in_red}) - signed'({1'b0, in_green});
    end
    if (rge && gge) begin
      mn = in_blue;
    end else if (rge) begin
      mn = in_green;
    end else if (rgeb) begin
      mn = in_blue;
    end else begin
      mn = in_red;
    end
  end

  logic                  a_valid_r;
  r2h_sel_t              a_sel_r;
  logic [PIX_W-1:0]      a_max_r;
  logic [PIX_W-1:0]      a_d_r;
  logic signed [PIX_W:0] a_diff_r;
  logic                  a_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    a_sel_r  <= sel;
    a_max_r  <= mx;
    a_d_r    <= mx - mn;
    a_diff_r <= diff;
    a_fe_r   <= in_frame_end;
  end

  // Stage B: hue numerator, which always lies in [0, 6d).
  logic [HDEN_W-1:0]        d2, d4, d6, base;
  logic signed [HDEN_W:0]   n_sum;
  logic [HDEN_W-1:0]        n_nxt;

  assign d2 = HDEN_W'(a_d_r) << 1;
  assign d4 = HDEN_W'(a_d_r) << 2;
  assign d6 = d2 + d4;

  always_comb begin
    case (a_sel_r)
      MAX_RED:   base = a_diff_r[PIX_W] ? d6 : '0;
      MAX_GREEN: base = d2;
      MAX_BLUE:  base = d4;
      default:   base = '0;
    endcase
    n_sum = signed'({1'b0, base}) + (HDEN_W + 1)'(a_diff_r);
    n_nxt = n_sum[HDEN_W-1:0];
  end

  logic              b_valid_r;
  logic [HDEN_W-1:0] b_n_r;
  logic [PIX_W-1:0]  b_d_r;
  logic [PIX_W-1:0]  b_max_r;
  logic              b_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    b_n_r   <= n_nxt;
    b_d_r   <= a_d_r;
    b_max_r <= a_max_r;
    b_fe_r  <= a_fe_r;
  end

  // Stage C: scale the numerators by 255 and form the hue divisor 6d.
  logic [HNUM_W-1:0] hnum_nxt;
  logic [HDEN_W-1:0] hden_nxt;
  logic [SNUM_W-1:0] snum_nxt;

  assign hnum_nxt = (HNUM_W'(b_n_r) << Q_W) - HNUM_W'(b_n_r);
  assign hden_nxt = (HDEN_W'(b_d_r) << 2) + (HDEN_W'(b_d_r) << 1);
  assign snum_nxt = (SNUM_W'(b_d_r) << Q_W) - SNUM_W'(b_d_r);

  r2h_ctl_t          c_ctl_r;
  logic              c_valid_r;
  logic [HNUM_W-1:0] c_hnum_r;
  logic [HDEN_W-1:0] c_hden_r;
  logic [SNUM_W-1:0] c_snum_r;
  logic [SDEN_W-1:0] c_sden_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    c_ctl_r.valid     <= 1'b0;
    c_ctl_r.gray      <= (b_d_r == '0);
    c_ctl_r.frame_end <= b_fe_r;
    c_ctl_r.val       <= b_max_r;
    c_hnum_r          <= hnum_nxt;
    c_hden_r          <= hden_nxt;
    c_snum_r          <= snum_nxt;
    c_sden_r          <= b_max_r;
  end

  // Division pipeline, most significant quotient bit first.
  r2h_ctl_t          ctl   [Q_W+1];
  logic [HNUM_W-1:0] hrem  [Q_W+1];
  logic [HDEN_W-1:0] hden  [Q_W+1];
  logic [Q_W-1:0]    hq    [Q_W+1];
  logic [SNUM_W-1:0] srem  [Q_W+1];
  logic [SDEN_W-1:0] sden  [Q_W+1];
  logic [Q_W-1:0]    sq    [Q_W+1];

  always_comb begin
    ctl[0]       = c_ctl_r;
    ctl[0].valid = c_valid_r;
  end

  assign hrem[0] = c_hnum_r;
  assign hden[0] = c_hden_r;
  assign hq[0]   = '0;
  assign srem[0] = c_snum_r;
  assign sden[0] = c_sden_r;
  assign sq[0]   = '0;

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    r2h_div_stage #(
      .BIT (Q_W - 1 - i)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl[i]),
      .hrem_i (hrem[i]),
      .hden_i (hden[i]),
      .hq_i   (hq[i]),
      .srem_i (srem[i]),
      .sden_i (sden[i]),
      .sq_i   (sq[i]),
      .ctl_o  (ctl[i+1]),
      .hrem_o (hrem[i+1]),
      .hden_o (hden[i+1]),
      .hq_o   (hq[i+1]),
      .srem_o (srem[i+1]),
      .sden_o (sden[i+1]),
      .sq_o   (sq[i+1])
    );
  end

  // A gray pixel has a zero hue divisor and a zero saturation numerator, so its quotients are forced to zero here.
  assign out_valid         = ctl[Q_W].valid;
  assign out_sat_out       = ctl[Q_W].gray ? '0 : sq[Q_W];
  assign out_hue_out       = ctl[Q_W].gray ? '0 : hq[Q_W];
  assign out_val_out       = ctl[Q_W].val;
  assign out_frame_end_out = ctl[Q_W].frame_end;

`include "rgb_to_hsv_pixel_converter_assert.svh"

  `R2H_ASSERT_SAME(a_out_has_request, out_valid, $past(accept, LATENCY))
  `R2H_ASSERT_SAME(a_black_is_zero, out_valid && (out_val_out == '0),
                   (out_sat_out == '0) && (out_hue_out == '0))
  `R2H_ASSERT_SAME(a_hue_below_full, out_valid, out_hue_out != '1)
  `R2H_ASSERT_NEXT(a_stage_a_follows, accept, a_valid_r)

endmodule

// ===== test/rgb_to_hsv_pixel_converter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rgb_to_hsv_pixel_converter: directed and random pixels,
// each checked against a behavioural HSV predictor. Depends on r2h_pkg and the block.
module rgb_to_hsv_pixel_converter_tb
  import r2h_pkg::*;
();

  localparam int unsigned LATENCY      = 11;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [PIX_W-1:0] sat;
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] val;
    logic             frame_end;
  } hsv_pixel_t;

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             start        = 1'b0;
  logic [PIX_W-1:0] in_red       = '0;
  logic [PIX_W-1:0] in_green     = '0;
  logic [PIX_W-1:0] in_blue      = '0;
  logic             in_frame_end = 1'b0;
  logic             busy;
  logic             out_valid;
  logic [PIX_W-1:0] out_sat_out;
  logic [PIX_W-1:0] out_hue_out;
  logic [PIX_W-1:0] out_val_out;
  logic             out_frame_end_out;

  hsv_pixel_t  expected_hsv_q[$];
  int unsigned pixels_sent     = 0;
  int unsigned random_pixels   = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count  = 0;
  int unsigned cycle_count     = 0;

  rgb_to_hsv_pixel_converter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_frame_end     (in_frame_end),
    .out_valid        (out_valid),
    .out_sat_out      (out_sat_out),
    .out_hue_out      (out_hue_out),
    .out_val_out      (out_val_out),
    .out_frame_end_out(out_frame_end_out)
  );

  always #10 clk = ~clk;

  function automatic hsv_pixel_t predict_hsv(input logic [PIX_W-1:0] r,
                                             input logic [PIX_W-1:0] g,
                                             input logic [PIX_W-1:0] b,
                                             input logic             fe);
    hsv_pixel_t  px;
    r2h_sel_t    max_ch;
    int unsigned rv;
    int unsigned gv;
    int unsigned bv;
    int unsigned hi;
    int unsigned lo;
    int unsigned d;
    int unsigned num;
    rv = 32'(r);
    gv = 32'(g);
    bv = 32'(b);
    hi = rv;
    lo = rv;
    if (gv > hi) hi = gv;
    if (bv > hi) hi = bv;
    if (gv < lo) lo = gv;
    if (bv < lo) lo = bv;
    d = hi - lo;
    px.val       = hi[PIX_W-1:0];
    px.frame_end = fe;
    px.sat       = '0;
    px.hue       = '0;
    if (d != 0) begin
      // Ties go to red first, then green.
      if (hi == rv) max_ch = MAX_RED;
      else if (hi == gv) max_ch = MAX_GREEN;
      else max_ch = MAX_BLUE;
      case (max_ch)
        MAX_RED: begin
          if (gv >= bv) num = gv - bv;
          else num = 6 * d - (bv - gv);
        end
        MAX_GREEN: num = 2 * d + bv - rv;
        default:   num = 4 * d + rv - gv;
      endcase
      px.hue = PIX_W'((255 * num) / (6 * d));
      px.sat = PIX_W'((255 * d) / hi);
    end
    return px;
  endfunction

  // Drives one request and holds it until the block takes it.
  task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b, input logic fe);
    start        <= 1'b1;
    in_red       <= r;
    in_green     <= g;
    in_blue      <= b;
    in_frame_end <= fe;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    expected_hsv_q.push_back(predict_hsv(r, g, b, fe));
    pixels_sent++;
  endtask

  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 6));
  endtask

  task automatic wait_for_drain();
    while (expected_hsv_q.size() != 0) @(posedge clk);
  endtask

  // Mostly uniform pixels, with a share of gray, tied, near-gray and full-scale-channel ones.
  task automatic random_pixel(output logic [PIX_W-1:0] r, output logic [PIX_W-1:0] g,
                              output logic [PIX_W-1:0] b, output logic fe);
    logic [PIX_W-1:0] base;
    base = PIX_W'($urandom);
    r    = PIX_W'($urandom);
    g    = PIX_W'($urandom);
    b    = PIX_W'($urandom);
    fe   = ($urandom_range(0, 15) == 0);
    case ($urandom_range(0, 9))
      0: begin
        r = base;
        g = base;
        b = base;
      end
      1: begin
        case ($urandom_range(0, 2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end
      2: begin
        g = base + PIX_W'($urandom_range(0, 3));
        b = base - PIX_W'($urandom_range(0, 3));
        r = base;
      end
      3: begin
        case ($urandom_range(0, 2))
          0: r = '1;
          1: g = '1;
          default: b = '1;
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic test_directed_pixels();
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    send_pixel(8'd0,   8'd255, 8'd0,   1'b1);
    send_pixel(8'd0,   8'd0,   8'd255, 1'b0);
    maybe_gap();
    send_pixel(8'd255, 8'd255, 8'd0,   1'b0);
    send_pixel(8'd0,   8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0,   8'd255, 1'b1);
    send_pixel(8'd255, 8'd0,   8'd1,   1'b0);
    send_pixel(8'd255, 8'd1,   8'd0,   1'b0);
    send_pixel(8'd1,   8'd0,   8'd0,   1'b0);
    idle_cycles(3);
    send_pixel(8'd0,   8'd1,   8'd0,   1'b0);
    send_pixel(8'd0,   8'd0,   8'd1,   1'b1);
    send_pixel(8'd200, 8'd100, 8'd50,  1'b0);
    send_pixel(8'd50,  8'd200, 8'd100, 1'b0);
    send_pixel(8'd100, 8'd50,  8'd200, 1'b0);
    send_pixel(8'd255, 8'd254, 8'd254, 1'b0);
    send_pixel(8'd254, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd1,   8'd1,   8'd0,   1'b0);
    send_pixel(8'd170, 8'd85,  8'd255, 1'b0);
    send_pixel(8'd85,  8'd170, 8'd255, 1'b1);
    idle_cycles(1);
  endtask

  // Random pixels with bursty gaps; every so often the sender waits for the pipe to empty.
  task automatic test_random_with_gaps(input int unsigned count);
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic             fe;
    for (int unsigned i = 0; i < count; i++) begin
      random_pixel(r, g, b, fe);
      send_pixel(r, g, b, fe);
      random_pixels++;
      if (i % 250 == 249) begin
        idle_cycles(1);
        wait_for_drain();
      end else begin
        maybe_gap();
      end
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic             fe;
    for (int unsigned i = 0; i < count; i++) begin
      random_pixel(r, g, b, fe);
      send_pixel(r, g, b, fe);
      random_pixels++;
    end
    idle_cycles(1);
  endtask

  always @(posedge clk) begin
    hsv_pixel_t exp_px;
    if (rst_n === 1'b1) begin
      if (out_valid !== 1'b0 && out_valid !== 1'b1) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("ERROR: out_valid is unknown after reset");
      end else if (out_valid) begin
        if (expected_hsv_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: unexpected result: sat %0d hue %0d val %0d fe %0b",
                     out_sat_out, out_hue_out, out_val_out, out_frame_end_out);
        end else begin
          exp_px = expected_hsv_q.pop_front();
          results_checked++;
          if (out_sat_out !== exp_px.sat || out_hue_out !== exp_px.hue ||
              out_val_out !== exp_px.val || out_frame_end_out !== exp_px.frame_end) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("ERROR: result %0d: exp s/h/v/fe %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                       results_checked, exp_px.sat, exp_px.hue, exp_px.val, exp_px.frame_end,
                       out_sat_out, out_hue_out, out_val_out, out_frame_end_out);
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: run exceeded %0d cycles", LIMIT_CYCLES);
    $display("rgb_to_hsv_pixel_converter_tb failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_pixels();
    test_random_with_gaps(900);
    test_back_to_back(300);
    wait_for_drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (expected_hsv_q.size() != 0) begin
      mismatch_count++;
      $display("ERROR: %0d results never arrived", expected_hsv_q.size());
    end
    $display("Sent %0d pixels (%0d random) and checked %0d results.",
             pixels_sent, random_pixels, results_checked);
    $display("Covered gray, black, tied maxima, hue wrap-around and frame ends; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("rgb_to_hsv_pixel_converter_tb passed");
    end else begin
      $display("rgb_to_hsv_pixel_converter_tb failed");
    end
    $finish;
  end

endmodule
